[rtl/core/hcb_pkg.sv]
// Shared types and constants of the Huffman code builder.
`default_nettype none
package hcb_pkg;
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_MERGE  = 2'd3;

    localparam int DEPTH_W = 8;
    localparam int CNT_W   = 9;
    localparam int LEN_W   = 6;
    localparam int VAL_W   = 48;

    typedef struct packed {
        logic [1:0] op;
    } cell_ctl_t;
endpackage
`default_nettype wire

[rtl/core/huffman_code_builder_top.sv]
// Top level of the Huffman code builder: command handling, sorted cell chain and code walk.
`default_nettype none
// A load gives no result. A read raises its result through the registered read of the code
// memory and then the output register, once that register is free. A build streams leaf
// weights into the cell chain, performs live symbols minus one merges, walks each inner node
// through the child and walk memories in a read state, a left write state and a right write
// state, and finishes in the done state.
// Input is taken only while no command is in progress; one finished result may still be
// waiting on the output register when the next command is taken.
module huffman_code_builder_top #(
    parameter int SYMBOLS       = 256,
    parameter int FREQ_BITS     = 24,
    parameter int MAX_CODE_BITS = 48
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [7:0]  s_symbol,
    input  wire logic [23:0] s_frequency,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_present,
    output logic [5:0]       m_code_length,
    output logic [47:0]      m_code_value,
    output logic [8:0]       m_used_symbols
);
    localparam int WW = FREQ_BITS + 8;
    localparam int SW = $clog2(SYMBOLS);
    localparam int NW = $clog2(2 * SYMBOLS - 1);
    localparam int CW = $clog2(SYMBOLS + 1);
    localparam int DW = hcb_pkg::DEPTH_W;
    localparam int EW = MAX_CODE_BITS + DW;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILL  = 3'd1;
    localparam logic [2:0] ST_MERGE = 3'd2;
    localparam logic [2:0] ST_WRD   = 3'd3;
    localparam logic [2:0] ST_WL    = 3'd4;
    localparam logic [2:0] ST_WR    = 3'd5;
    localparam logic [2:0] ST_RD    = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]               state_reg, state_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [hcb_pkg::CNT_W-1:0] n_reg, n_next, live_reg, live_next;
    logic [SW-1:0]            made_reg, made_next, m_reg, m_next;
    logic [SYMBOLS-1:0]       lvalid_reg, lvalid_next, cvalid_reg, cvalid_next;
    logic                     lv_q_reg, lv_q_next, rd_ok_reg, rd_ok_next;
    logic [NW-1:0]            right_reg, right_next;
    logic [MAX_CODE_BITS-1:0] c_reg, c_next;
    logic [DW-1:0]            d_reg, d_next;
    logic                     mv_reg, mv_next, mp_reg, mp_next;
    logic [5:0]               ml_reg, ml_next;
    logic [47:0]              mc_reg, mc_next;
    logic [8:0]               mu_reg, mu_next;

    hcb_pkg::cell_ctl_t       ctl;
    logic [WW-1:0]            new_w;
    logic [NW-1:0]            new_id;
    logic                     cv  [SYMBOLS];
    logic [WW-1:0]            cw  [SYMBOLS];
    logic [NW-1:0]            cid [SYMBOLS];

    logic                     lf_we, lf_re;
    logic [SW-1:0]            lf_waddr, lf_raddr;
    logic [FREQ_BITS-1:0]     lf_wdata, lf_rdata;
    logic                     ch_we, ch_re;
    logic [SW-1:0]            ch_waddr, ch_raddr;
    logic [2*NW-1:0]          ch_wdata, ch_rdata;
    logic                     iw_we, iw_re;
    logic [SW-1:0]            iw_waddr, iw_raddr;
    logic [EW-1:0]            iw_wdata, iw_rdata;
    logic                     cs_we, cs_re;
    logic [SW-1:0]            cs_waddr, cs_raddr;
    logic [EW-1:0]            cs_wdata, cs_rdata;

    logic                     acc, out_free, sym_ok, root;
    logic                     wr_en;
    logic [NW-1:0]            wr_id, left_id;
    logic [MAX_CODE_BITS-1:0] wr_c, pc, nc;
    logic [DW-1:0]            wr_d, pd, nd;
    logic [WW-1:0]            fill_w;
    logic [63:0]              code_wide;

    // Sorted chain of cells, lightest entry in cell zero.
    for (genvar i = 0; i < SYMBOLS; i++) begin : g_cell
        logic          pv, n1v, n2v;
        logic [WW-1:0] pw, n1w, n2w;
        logic [NW-1:0] pid, n1id, n2id;
        if (i == 0) begin : g_first
            assign pv = 1'b1; assign pw = '0; assign pid = '0;
        end else begin : g_prev
            assign pv = cv[i-1]; assign pw = cw[i-1]; assign pid = cid[i-1];
        end
        if (i + 1 < SYMBOLS) begin : g_n1
            assign n1v = cv[i+1]; assign n1w = cw[i+1]; assign n1id = cid[i+1];
        end else begin : g_n1e
            assign n1v = 1'b0; assign n1w = '0; assign n1id = '0;
        end
        if (i + 2 < SYMBOLS) begin : g_n2
            assign n2v = cv[i+2]; assign n2w = cw[i+2]; assign n2id = cid[i+2];
        end else begin : g_n2e
            assign n2v = 1'b0; assign n2w = '0; assign n2id = '0;
        end
        hcb_cell #(.WW(WW), .NW(NW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .new_w(new_w), .new_id(new_id),
            .prev_v(pv), .prev_w(pw), .prev_id(pid),
            .nxt1_v(n1v), .nxt1_w(n1w), .nxt1_id(n1id),
            .nxt2_v(n2v), .nxt2_w(n2w), .nxt2_id(n2id),
            .q_v(cv[i]), .q_w(cw[i]), .q_id(cid[i])
        );
    end

    hcb_ram #(.WIDTH(FREQ_BITS), .DEPTH(SYMBOLS)) u_leaf (
        .aclk(aclk), .we(lf_we), .waddr(lf_waddr), .wdata(lf_wdata),
        .re(lf_re), .raddr(lf_raddr), .rdata(lf_rdata)
    );
    hcb_ram #(.WIDTH(2 * NW), .DEPTH(SYMBOLS)) u_child (
        .aclk(aclk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .re(ch_re), .raddr(ch_raddr), .rdata(ch_rdata)
    );
    hcb_ram #(.WIDTH(EW), .DEPTH(SYMBOLS)) u_walk (
        .aclk(aclk), .we(iw_we), .waddr(iw_waddr), .wdata(iw_wdata),
        .re(iw_re), .raddr(iw_raddr), .rdata(iw_rdata)
    );
    hcb_ram #(.WIDTH(EW), .DEPTH(SYMBOLS)) u_code (
        .aclk(aclk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
        .re(cs_re), .raddr(cs_raddr), .rdata(cs_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign acc      = s_valid && s_ready;
    assign out_free = !mv_reg || m_ready;
    assign sym_ok   = ({1'b0, s_symbol} < 9'(SYMBOLS));
    assign root     = (m_reg == made_reg - SW'(1));
    assign fill_w   = lv_q_reg ? WW'(lf_rdata) : '0;
    assign left_id  = ch_rdata[2*NW-1:NW];
    assign pc       = root ? '0 : iw_rdata[MAX_CODE_BITS-1:0];
    assign pd       = root ? '0 : iw_rdata[EW-1:MAX_CODE_BITS];
    assign nc       = {pc[MAX_CODE_BITS-2:0], 1'b0};
    assign nd       = pd + DW'(1);
    assign code_wide = 64'(cs_rdata[MAX_CODE_BITS-1:0]);

    always_comb begin
        state_next = state_reg; cnt_next = cnt_reg; n_next = n_reg; live_next = live_reg;
        made_next = made_reg; m_next = m_reg; lvalid_next = lvalid_reg;
        cvalid_next = cvalid_reg; lv_q_next = lv_q_reg; rd_ok_next = rd_ok_reg;
        right_next = right_reg; c_next = c_reg; d_next = d_reg;
        mv_next = mv_reg && !m_ready; mp_next = mp_reg; ml_next = ml_reg;
        mc_next = mc_reg; mu_next = mu_reg;
        ctl.op = hcb_pkg::OP_HOLD; new_w = fill_w; new_id = NW'(cnt_reg - CW'(1));
        lf_we = 1'b0; lf_waddr = s_symbol[SW-1:0]; lf_wdata = FREQ_BITS'(s_frequency);
        lf_re = 1'b0; lf_raddr = cnt_reg[SW-1:0];
        ch_we = 1'b0; ch_waddr = made_reg; ch_wdata = '0;
        ch_re = 1'b0; ch_raddr = m_reg;
        iw_re = 1'b0; iw_raddr = m_reg;
        cs_re = 1'b0; cs_raddr = s_symbol[SW-1:0];
        wr_en = 1'b0; wr_id = left_id; wr_c = nc; wr_d = nd;

        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    unique case (s_command)
                        hcb_pkg::CMD_LOAD: begin
                            if (sym_ok) begin
                                lf_we = 1'b1;
                                lvalid_next[s_symbol[SW-1:0]] = 1'b1;
                            end
                        end
                        hcb_pkg::CMD_BUILD: begin
                            ctl.op = hcb_pkg::OP_CLEAR;
                            cvalid_next = '0;
                            cnt_next = '0; n_next = '0; made_next = '0;
                            state_next = ST_FILL;
                        end
                        hcb_pkg::CMD_READ: begin
                            cs_re = 1'b1;
                            rd_ok_next = sym_ok && cvalid_reg[s_symbol[SW-1:0]];
                            state_next = ST_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                if (cnt_reg < CW'(SYMBOLS)) begin
                    lf_re = 1'b1;
                    lv_q_next = lvalid_reg[cnt_reg[SW-1:0]];
                end
                if (cnt_reg != '0 && fill_w != '0) begin
                    ctl.op = hcb_pkg::OP_INSERT;
                    n_next = n_reg + hcb_pkg::CNT_W'(1);
                end
                if (cnt_reg == CW'(SYMBOLS)) begin
                    live_next = n_next;
                    state_next = ST_MERGE;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_MERGE: begin
                if (n_reg > hcb_pkg::CNT_W'(1)) begin
                    // On equal weights, cell one holds the earlier entry and becomes the left child.
                    ctl.op = hcb_pkg::OP_MERGE;
                    new_w = cw[0] + cw[1];
                    new_id = NW'(SYMBOLS) + NW'(made_reg);
                    ch_we = 1'b1;
                    ch_wdata = (cw[0] < cw[1]) ? {cid[0], cid[1]} : {cid[1], cid[0]};
                    made_next = made_reg + SW'(1);
                    n_next = n_reg - hcb_pkg::CNT_W'(1);
                end else if (n_reg == '0) begin
                    state_next = ST_DONE;
                end else if (made_reg == '0) begin
                    wr_en = 1'b1; wr_id = cid[0]; wr_c = '0; wr_d = '0;
                    state_next = ST_DONE;
                end else begin
                    m_next = made_reg - SW'(1);
                    state_next = ST_WRD;
                end
            end
            ST_WRD: begin
                ch_re = 1'b1;
                iw_re = 1'b1;
                state_next = ST_WL;
            end
            ST_WL: begin
                wr_en = 1'b1;
                right_next = ch_rdata[NW-1:0];
                c_next = nc | MAX_CODE_BITS'(1);
                d_next = nd;
                state_next = ST_WR;
            end
            ST_WR: begin
                wr_en = 1'b1; wr_id = right_reg; wr_c = c_reg; wr_d = d_reg;
                if (m_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    m_next = m_reg - SW'(1);
                    state_next = ST_WRD;
                end
            end
            ST_RD: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    mp_next = rd_ok_reg;
                    ml_next = rd_ok_reg ? cs_rdata[MAX_CODE_BITS+5:MAX_CODE_BITS] : '0;
                    mc_next = rd_ok_reg ? code_wide[47:0] : '0;
                    mu_next = live_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                if (out_free) begin
                    mv_next = 1'b1; mp_next = 1'b0; ml_next = '0; mc_next = '0;
                    mu_next = live_reg;
                    state_next = ST_IDLE;
                end
            end
        endcase

        // Child write: inner nodes go to the walk memory, leaves to the code memory if their depth fits MAX_CODE_BITS.
        iw_we = wr_en && (wr_id >= NW'(SYMBOLS));
        iw_waddr = SW'(wr_id - NW'(SYMBOLS));
        iw_wdata = {wr_d, wr_c};
        cs_we = wr_en && (wr_id < NW'(SYMBOLS)) && (wr_d <= DW'(MAX_CODE_BITS));
        cs_waddr = wr_id[SW-1:0];
        cs_wdata = {wr_d, wr_c};
        if (cs_we) begin
            cvalid_next[wr_id[SW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            lvalid_reg <= '0;
            cvalid_reg <= '0;
            live_reg   <= '0;
            mv_reg     <= 1'b0;
            cnt_reg    <= '0;
            n_reg      <= '0;
            made_reg   <= '0;
            m_reg      <= '0;
        end else begin
            state_reg  <= state_next;
            lvalid_reg <= lvalid_next;
            cvalid_reg <= cvalid_next;
            live_reg   <= live_next;
            mv_reg     <= mv_next;
            cnt_reg    <= cnt_next;
            n_reg      <= n_next;
            made_reg   <= made_next;
            m_reg      <= m_next;
        end
        lv_q_reg  <= lv_q_next;
        rd_ok_reg <= rd_ok_next;
        right_reg <= right_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        mp_reg    <= mp_next;
        ml_reg    <= ml_next;
        mc_reg    <= mc_next;
        mu_reg    <= mu_next;
    end

    assign m_valid        = mv_reg;
    assign m_present      = mp_reg;
    assign m_code_length  = ml_reg;
    assign m_code_value   = mc_reg;
    assign m_used_symbols = mu_reg;

    a_merge_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE && n_reg > hcb_pkg::CNT_W'(1)) |-> (cv[0] && cv[1]))
        else $error("merge with fewer than two live cells");
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= hcb_pkg::CNT_W'(SYMBOLS))
        else $error("live count beyond symbol count");
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mv_reg) |-> $past(state_reg == ST_RD || state_reg == ST_DONE))
        else $error("result raised outside read or done");
    a_build_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && s_command == hcb_pkg::CMD_BUILD) |=> (cvalid_reg == '0))
        else $error("codes not cleared at build");
endmodule
`default_nettype wire

[rtl/core/hcb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/core/hcb_cell.sv]
// One cell of the sorted list: holds one entry, ascending weight from cell zero.
`default_nettype none
module hcb_cell #(
    parameter int WW = 32,
    parameter int NW = 9
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire hcb_pkg::cell_ctl_t ctl,
    input  wire logic [WW-1:0]     new_w,
    input  wire logic [NW-1:0]     new_id,
    input  wire logic              prev_v,
    input  wire logic [WW-1:0]     prev_w,
    input  wire logic [NW-1:0]     prev_id,
    input  wire logic              nxt1_v,
    input  wire logic [WW-1:0]     nxt1_w,
    input  wire logic [NW-1:0]     nxt1_id,
    input  wire logic              nxt2_v,
    input  wire logic [WW-1:0]     nxt2_w,
    input  wire logic [NW-1:0]     nxt2_id,
    output logic                   q_v,
    output logic      [WW-1:0]     q_w,
    output logic      [NW-1:0]     q_id
);
    logic          v_reg, v_next;
    logic [WW-1:0] w_reg, w_next;
    logic [NW-1:0] id_reg, id_next;
    logic          h_v, p_v, h_lt, p_lt;
    logic [WW-1:0] h_w, p_w;
    logic [NW-1:0] h_id, p_id;

    // A merge drops the two lightest entries, so the cell looks two and one places up.
    always_comb begin
        if (ctl.op == hcb_pkg::OP_MERGE) begin
            h_v = nxt2_v; h_w = nxt2_w; h_id = nxt2_id;
            p_v = nxt1_v; p_w = nxt1_w; p_id = nxt1_id;
        end else begin
            h_v = v_reg;  h_w = w_reg;  h_id = id_reg;
            p_v = prev_v; p_w = prev_w; p_id = prev_id;
        end
        h_lt = h_v && (h_w < new_w);
        p_lt = p_v && (p_w < new_w);
        v_next = v_reg; w_next = w_reg; id_next = id_reg;
        unique case (ctl.op)
            hcb_pkg::OP_HOLD: begin
            end
            hcb_pkg::OP_CLEAR: begin
                v_next = 1'b0;
            end
            default: begin
                if (h_lt) begin
                    v_next = h_v; w_next = h_w; id_next = h_id;
                end else if (p_lt) begin
                    v_next = 1'b1; w_next = new_w; id_next = new_id;
                end else begin
                    v_next = p_v; w_next = p_w; id_next = p_id;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else begin
            v_reg <= v_next;
        end
        w_reg  <= w_next;
        id_reg <= id_next;
    end

    assign q_v  = v_reg;
    assign q_w  = w_reg;
    assign q_id = id_reg;
endmodule
`default_nettype wire
